### rtl/core/wtrm_pkg.sv
// Shared types and constants for the windowed true-RMS meter.
`default_nettype none

package wtrm_pkg;

   // Default build values.
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int MAX_WINDOW_DEF  = 1024;

   // Configuration register widths and the write port.
   localparam int CFG_COUNT_W = 11;
   localparam int CFG_FS_W    = 13;
   localparam int CFG_OFS_W   = 10;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_IDX_W   = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE_MV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_MV     = 2'd2;

   // Register values after reset.
   localparam logic [CFG_COUNT_W-1:0] SAMPLE_COUNT_RST  = 11'd300;
   localparam logic [CFG_FS_W-1:0]    FULL_SCALE_MV_RST = 13'd3300;
   localparam logic [CFG_OFS_W-1:0]   OFFSET_MV_RST     = 10'd110;

   // Millivolt scaling: full scale belongs to code 4096, so divide by a shift.
   localparam int CODE_SHIFT = 12;
   localparam int MV_W       = 13;
   localparam logic [MV_W-1:0] MV_LIMIT = 13'd6000;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ROOT,
      ST_SCALE,
      ST_EMIT
   } wtrm_state_type;

endpackage

`default_nettype wire

### rtl/core/windowed_true_rms_meter.sv
// Windowed true-RMS meter: serial square, divide, root and millivolt scaling.
//
//   Channel  Ports                          Direction  Moves
//   req      req_valid/req_ready/req_sample  in         one ADC sample per request
//   rsp      rsp_valid/rsp_ready/rsp_*       out        one result per closed window
//   csr      csr_we/csr_index/csr_wdata      in         register write, no wait
//
// Every request passes through the bit-serial square, one multiplier bit per
// step. The request that closes a window then runs a restoring division of the
// window sum by its sample count, a square root of the quotient, and the
// millivolt scaling and output load.
// Reset is synchronous; it clears the sequencer and the window and loads the registers with their reset values.
// A result waiting on rsp does not stop new requests; only the next result
// stalls, in its output cycle, until the held one is taken.
`default_nettype none

module windowed_true_rms_meter #(
   parameter int SAMPLE_BITS = wtrm_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = wtrm_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Sample requests.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   // Results.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2*SAMPLE_BITS-1:0]         rsp_mean_square,
   output logic [SAMPLE_BITS-1:0]           rsp_rms_code,
   output logic [wtrm_pkg::MV_W-1:0]        rsp_rms_mv,
   // Configuration writes.
   input  logic                             csr_we,
   input  logic [wtrm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wtrm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wtrm_pkg::*;

   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int SQ_W    = 2 * SAMPLE_BITS;
   localparam int SUM_W   = SQ_W + CNT_W;
   localparam int STEP_W  = $clog2(SUM_W);
   localparam int CMP_W   = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;
   localparam int REM_W   = SAMPLE_BITS + 1;
   localparam int TRY_W   = SAMPLE_BITS + 3;
   localparam int PROD_W  = SAMPLE_BITS + CFG_FS_W;
   localparam int MVS_W   = (SAMPLE_BITS + 2 > MV_W + 1) ? SAMPLE_BITS + 2 : MV_W + 1;

   // Sequencer and configuration.
   wtrm_state_type           state_ff, state_in;
   logic [CFG_COUNT_W-1:0]   sample_count_ff;
   logic [CFG_FS_W-1:0]      full_scale_mv_ff;
   logic [CFG_OFS_W-1:0]     offset_mv_ff;
   logic [STEP_W-1:0]        step_ff;

   // Window accumulation.
   logic [SUM_W-1:0]         sum_ff;
   logic [CNT_W-1:0]         seen_ff;
   logic [SAMPLE_BITS-1:0]   mplier_ff;
   logic [SQ_W-1:0]          mcand_ff;

   // Division, root and scaling.
   logic [SUM_W-1:0]         dq_ff;
   logic [CNT_W-1:0]         div_rem_ff;
   logic [CNT_W-1:0]         divisor_ff;
   logic [SQ_W-1:0]          mean_ff;
   logic [SQ_W-1:0]          rad_ff;
   logic [REM_W-1:0]         sq_rem_ff;
   logic [SAMPLE_BITS-1:0]   root_ff;
   logic [PROD_W-1:0]        prod_ff;

   // Output register.
   logic                     rsp_valid_ff;
   logic [SQ_W-1:0]          rsp_mean_ff;
   logic [SAMPLE_BITS-1:0]   rsp_root_ff;
   logic [MV_W-1:0]          rsp_mv_ff;

   logic                     out_free;
   logic [SUM_W-1:0]         sum_in;
   logic [CNT_W-1:0]         held;
   logic [CNT_W-1:0]         window;
   logic [CMP_W-1:0]         count_ext;
   logic                     close_window;
   logic [CNT_W:0]           div_try;
   logic                     div_fits;
   logic [TRY_W-1:0]         sq_shift;
   logic [TRY_W-1:0]         sq_try;
   logic                     sq_fits;
   logic [MVS_W-1:0]         mv_sum;
   logic [MV_W-1:0]          mv_sat;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Effective window: zero acts as one, large values clamp to the maximum.
   assign count_ext = CMP_W'(sample_count_ff);
   always_comb begin
      if (sample_count_ff == '0) begin
         window = CNT_W'(1);
      end else if (count_ext > CMP_W'(MAX_WINDOW)) begin
         window = CNT_W'(MAX_WINDOW);
      end else begin
         window = CNT_W'(count_ext);
      end
   end

   // One shift-add step of the square; the last step also decides the window.
   assign sum_in       = mplier_ff[0] ? sum_ff + SUM_W'(mcand_ff) : sum_ff;
   assign held         = seen_ff + CNT_W'(1);
   assign close_window = !(held < window);

   // Restoring division step: one quotient bit per cycle.
   assign div_try  = {div_rem_ff, dq_ff[SUM_W-1]};
   assign div_fits = div_try >= {1'b0, divisor_ff};

   // Square root step: two radicand bits in, one root bit out per cycle.
   assign sq_shift = {sq_rem_ff, rad_ff[SQ_W-1 -: 2]};
   assign sq_try   = TRY_W'({root_ff, 2'b01});
   assign sq_fits  = sq_shift >= sq_try;

   // Millivolt scaling and saturation.
   assign mv_sum = MVS_W'(prod_ff >> CODE_SHIFT) + MVS_W'(offset_mv_ff);
   assign mv_sat = (mv_sum > MVS_W'(MV_LIMIT)) ? MV_LIMIT : MV_W'(mv_sum);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (step_ff == '0) state_in = close_window ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (step_ff == '0) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (step_ff == '0) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      rsp_valid       = rsp_valid_ff;
      rsp_mean_square = rsp_mean_ff;
      rsp_rms_code    = rsp_root_ff;
      rsp_rms_mv      = rsp_mv_ff;
   end

   // Sequencer, configuration and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         sample_count_ff  <= SAMPLE_COUNT_RST;
         full_scale_mv_ff <= FULL_SCALE_MV_RST;
         offset_mv_ff     <= OFFSET_MV_RST;
         sum_ff           <= '0;
         seen_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Register writes; an unused index is dropped.
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_COUNT: begin
                  sample_count_ff <= csr_wdata[CFG_COUNT_W-1:0];
               end
               CSR_FULL_SCALE_MV: begin
                  full_scale_mv_ff <= csr_wdata[CFG_FS_W-1:0];
               end
               CSR_OFFSET_MV: begin
                  offset_mv_ff <= csr_wdata[CFG_OFS_W-1:0];
               end
               default: begin
               end
            endcase
         end

         // Accumulate the square; a closing window hands its sum to the divider.
         if (state_ff == ST_SQUARE) begin
            if (step_ff != '0) begin
               sum_ff <= sum_in;
            end else if (close_window) begin
               sum_ff  <= '0;
               seen_ff <= '0;
            end else begin
               sum_ff  <= sum_in;
               seen_ff <= held;
            end
         end

         // The result register empties when taken and fills in the output cycle.
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Serial datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            mplier_ff <= req_sample;
            mcand_ff  <= SQ_W'(req_sample);
            step_ff   <= STEP_W'(SAMPLE_BITS - 1);
         end
         ST_SQUARE: begin
            mplier_ff  <= mplier_ff >> 1;
            mcand_ff   <= mcand_ff << 1;
            dq_ff      <= sum_in;
            divisor_ff <= held;
            div_rem_ff <= '0;
            if (step_ff == '0) begin
               step_ff <= STEP_W'(SUM_W - 1);
            end else begin
               step_ff <= step_ff - STEP_W'(1);
            end
         end
         ST_DIVIDE: begin
            dq_ff      <= {dq_ff[SUM_W-2:0], div_fits};
            div_rem_ff <= div_fits ? CNT_W'(div_try - {1'b0, divisor_ff})
                                   : CNT_W'(div_try);
            sq_rem_ff  <= '0;
            root_ff    <= '0;
            if (step_ff == '0) begin
               rad_ff  <= {dq_ff[SQ_W-2:0], div_fits};
               mean_ff <= {dq_ff[SQ_W-2:0], div_fits};
               step_ff <= STEP_W'(SAMPLE_BITS - 1);
            end else begin
               step_ff <= step_ff - STEP_W'(1);
            end
         end
         ST_ROOT: begin
            rad_ff    <= rad_ff << 2;
            sq_rem_ff <= sq_fits ? REM_W'(sq_shift - sq_try) : REM_W'(sq_shift);
            root_ff   <= {root_ff[SAMPLE_BITS-2:0], sq_fits};
            step_ff   <= step_ff - STEP_W'(1);
         end
         ST_SCALE: begin
            prod_ff <= PROD_W'(root_ff) * PROD_W'(full_scale_mv_ff);
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_mean_ff <= mean_ff;
               rsp_root_ff <= root_ff;
               rsp_mv_ff   <= mv_sat;
            end
         end
         default: begin
            step_ff <= '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/wtrm_checker.sv
// Port-level assertions for the windowed true-RMS meter, bound to its top level.
`default_nettype none

module wtrm_checker #(
   parameter int SAMPLE_BITS = wtrm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [2*SAMPLE_BITS-1:0]         rsp_mean_square,
   input  logic [SAMPLE_BITS-1:0]           rsp_rms_code,
   input  logic [wtrm_pkg::MV_W-1:0]        rsp_rms_mv
);
   import wtrm_pkg::*;

   localparam int CHK_W = 2 * SAMPLE_BITS + 2;

   logic [CHK_W-1:0] root_sq;
   logic [CHK_W-1:0] next_sq;
   logic [CHK_W-1:0] mean_ext;

   assign root_sq  = CHK_W'(rsp_rms_code) * CHK_W'(rsp_rms_code);
   assign next_sq  = (CHK_W'(rsp_rms_code) + CHK_W'(1)) * (CHK_W'(rsp_rms_code) + CHK_W'(1));
   assign mean_ext = CHK_W'(rsp_mean_square);

   // A held result keeps its payload until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_square)
         && $stable(rsp_rms_code) && $stable(rsp_rms_mv))
      else $error("result changed while stalled");

   // The serial square keeps the block busy right after it takes a request.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is still squaring");

   // A new result only appears out of a busy cycle.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work in progress");

   // The root code is the floor square root of the mean square.
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> root_sq <= mean_ext && next_sq > mean_ext)
      else $error("rms code is not the floor root of the mean square");

   // The millivolt value never passes the saturation limit.
   a_mv_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms_mv <= MV_LIMIT)
      else $error("millivolt result above the limit");

endmodule

bind windowed_true_rms_meter wtrm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wtrm_checker (.*);

`default_nettype wire
